>>> rtl/core/flpa_pkg.sv
// flpa_pkg: shared types and constants of the free-list page allocator
// used by flpa_ctrl, flpa_dp and free_list_page_allocator_core; no dependencies
`default_nettype none

package flpa_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W     = 32;
    localparam int FP_W       = ADDR_W + 1;            // first page may round up to 2^32
    localparam int PAGE_IDX_W = $clog2(NUM_PAGES);
    localparam int LIM_W      = $clog2(NUM_PAGES + 1);
    localparam int CNT_W      = FP_W - PAGE_SHIFT;
    localparam int CFG_IDX_W  = 1;

    localparam logic [FP_W-1:0] PAGE_MASK = FP_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    // item kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP  = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] page_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } t_rsp;

    typedef struct packed {
        logic [PAGE_IDX_W-1:0] next;
        logic                  last;
    } t_link;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic init_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       init_go;
        logic       init_last;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/flpa_ctrl.sv
// flpa_ctrl: sequencing state machine of the page allocator
// depends on flpa_pkg
`default_nettype none

module flpa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire flpa_pkg::t_sts i_sts,
    output flpa_pkg::t_cmd     o_cmd
);
    import flpa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_INIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       init_walk;

    assign init_walk = (i_sts.kind == KIND_INIT) && i_sts.init_go;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (init_walk) begin
                    n_state = S_INIT;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/flpa_dp.sv
// flpa_dp: region registers, head pointer, link memory, address checks and result register
// depends on flpa_pkg; driven by flpa_ctrl
`default_nettype none

module flpa_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire flpa_pkg::t_req                    i_req,
    input  wire logic                              i_cfg_valid,
    input  wire logic [flpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [flpa_pkg::ADDR_W-1:0]       i_cfg_data,
    input  wire flpa_pkg::t_cmd                    i_cmd,
    output flpa_pkg::t_sts                         o_sts,
    output logic                                   o_done,
    output flpa_pkg::t_rsp                         o_rsp
);
    import flpa_pkg::*;

    logic [ADDR_W-1:0]     r_region_base;
    logic [ADDR_W-1:0]     r_region_top;
    logic [FP_W-1:0]       r_first_page;
    t_req                  r_req;
    logic [PAGE_IDX_W-1:0] r_head;
    logic                  r_head_valid;
    t_link                 r_link_mem [NUM_PAGES];
    t_link                 r_rd_link;
    logic [PAGE_IDX_W-1:0] r_idx;
    logic [LIM_W-1:0]      r_limit;
    logic                  r_init_err;
    logic                  r_done;
    t_rsp                  r_rsp;

    logic [FP_W-1:0]       cfg_first_page;
    logic [FP_W-1:0]       free_diff;
    logic [FP_W-1:0]       top_diff;
    logic [CNT_W-1:0]      init_cnt;
    logic                  init_over;
    logic [LIM_W-1:0]      init_limit;
    logic                  free_ok;
    logic                  wr_en;
    logic [PAGE_IDX_W-1:0] wr_idx;
    logic [FP_W-1:0]       grant_sum;
    t_rsp                  n_rsp;

    // base rounded up to a page boundary, taken from the written value
    assign cfg_first_page = ({1'b0, i_cfg_data} + PAGE_MASK) & ~PAGE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= '0;
            r_region_top  <= '0;
            r_first_page  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_REGION_BASE: begin
                    r_region_base <= i_cfg_data;
                    r_first_page  <= cfg_first_page;
                end
                REG_REGION_TOP: begin
                    r_region_top <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
    end

    // free address checks
    assign free_diff = {1'b0, r_req.page_address} - r_first_page;
    assign free_ok   = (r_req.page_address[PAGE_SHIFT-1:0] == '0)
                    && (r_req.page_address >= r_region_base)
                    && (r_req.page_address < r_region_top)
                    && !free_diff[FP_W-1]
                    && (free_diff[FP_W-1:PAGE_SHIFT] < CNT_W'(NUM_PAGES));

    // whole pages in the range, clamped to table capacity
    assign top_diff   = {1'b0, r_region_top} - r_first_page;
    assign init_cnt   = top_diff[FP_W-1] ? '0 : top_diff[FP_W-1:PAGE_SHIFT];
    assign init_over  = init_cnt > CNT_W'(NUM_PAGES);
    assign init_limit = init_over ? LIM_W'(NUM_PAGES) : init_cnt[LIM_W-1:0];

    assign o_sts.kind      = r_req.kind;
    assign o_sts.init_go   = (init_limit != '0);
    assign o_sts.init_last = (({1'b0, r_idx} + LIM_W'(1)) == r_limit);

    // single write port: a free push or an init walk step
    always_comb begin
        wr_en  = 1'b0;
        wr_idx = r_idx;
        if (i_cmd.init_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.eval && (r_req.kind == KIND_FREE) && free_ok) begin
            wr_en  = 1'b1;
            wr_idx = free_diff[PAGE_SHIFT +: PAGE_IDX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link_mem[wr_idx] <= '{next: r_head, last: !r_head_valid};
        end
        r_rd_link <= r_link_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_head_valid <= 1'b0;
        end else if (wr_en) begin
            r_head       <= wr_idx;
            r_head_valid <= 1'b1;
        end else if (i_cmd.eval && (r_req.kind == KIND_ALLOC) && r_head_valid) begin
            r_head       <= r_rd_link.last ? '0 : r_rd_link.next;
            r_head_valid <= !r_rd_link.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_idx      <= '0;
            r_limit    <= init_limit;
            r_init_err <= init_over;
        end else if (i_cmd.init_step) begin
            r_idx <= r_idx + PAGE_IDX_W'(1);
        end
    end

    assign grant_sum = r_first_page + (FP_W'(r_head) << PAGE_SHIFT);

    always_comb begin
        n_rsp = '{granted_address: '0, status: ST_OK};
        if (i_cmd.init_step) begin
            n_rsp.status = r_init_err ? ST_ERROR : ST_OK;
        end else begin
            case (r_req.kind)
                KIND_ALLOC: begin
                    if (r_head_valid) begin
                        n_rsp.granted_address = grant_sum[ADDR_W-1:0];
                    end else begin
                        n_rsp.status = ST_EMPTY;
                    end
                end
                KIND_FREE: begin
                    n_rsp.status = free_ok ? ST_OK : ST_ERROR;
                end
                KIND_INIT: begin
                    n_rsp.status = init_over ? ST_ERROR : ST_OK;
                end
                default: begin
                    n_rsp.status = ST_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for two cycles");

    a_grant_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_rsp.status != ST_OK)) |-> (r_rsp.granted_address == '0))
        else $error("address granted with a failing status");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.init_step |-> ({1'b0, r_idx} < r_limit))
        else $error("init walk ran past its page count");

    a_push_sets_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_head_valid)
        else $error("head not valid after a push");

endmodule

`default_nettype wire

>>> rtl/core/free_list_page_allocator_core.sv
// free_list_page_allocator_core: top level of the LIFO page allocator
// depends on flpa_pkg, flpa_ctrl, flpa_dp
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------
//  item    | in        | start & !busy               | i_req (kind, page_address)
//  result  | out       | o_done, one cycle           | o_rsp (granted_address, status)
//  config  | in        | i_cfg_valid & o_cfg_ready   | i_cfg_index, i_cfg_data
//
// alloc, free and unused kinds are captured in S_IDLE and finish in S_EVAL: the head page's
// link is read into a register while the item is captured, and the head is updated in S_EVAL.
// init with N pages to push (N at most NUM_PAGES) then steps through S_INIT, one link
// memory write per cycle on the single write port.
// reset empties the list; link entries are left as they are and are never used unwritten.
// results cannot be stalled; busy drops in the cycle o_done is shown.
`default_nettype none

module free_list_page_allocator_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire flpa_pkg::t_req                    i_req,
    output logic                                   o_done,
    output flpa_pkg::t_rsp                         o_rsp,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [flpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [flpa_pkg::ADDR_W-1:0]       i_cfg_data
);
    import flpa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    flpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    flpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

>>> tb/free_list_page_allocator_core_test.sv
// free_list_page_allocator_core_test: self-checking testbench of the page allocator core
// needs flpa_pkg and free_list_page_allocator_core; a table of directed items, then random
// phases over several region settings, results compared with the table or a free-list predictor
`default_nettype none

module free_list_page_allocator_core_test;
    import flpa_pkg::*;

    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    localparam int         PAGE_BYTES      = 1 << PAGE_SHIFT;
    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 75;
    localparam int         SETTLE_CYCLES   = 20;
    localparam int         REPORT_LIMIT    = 10;
    localparam longint     CYCLE_LIMIT     = 3_000_000;

    typedef struct {
        bit                is_region;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] top;
        t_req              req;
        bit                known;
        t_rsp              rsp;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_done;
    t_rsp                  o_rsp;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [ADDR_W-1:0]     i_cfg_data;

    // predicted allocator state
    logic [ADDR_W-1:0]     region_base;
    logic [ADDR_W-1:0]     region_top;
    logic [PAGE_IDX_W-1:0] head_page;
    bit                    head_valid;
    t_link                 page_link [NUM_PAGES];

    t_rsp                  expected_rsp[$];
    logic [ADDR_W-1:0]     granted_pool[$];
    t_row                  directed_rows[$];
    int                    mismatches = 0;
    longint                cycle_count = 0;

    free_list_page_allocator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // region_base rounded up to a page, 33 bits wide since it may reach 2^32
    function automatic logic [FP_W-1:0] first_page();
        return ({1'b0, region_base} + FP_W'(PAGE_BYTES - 1)) & ~PAGE_MASK;
    endfunction

    function automatic longint range_pages();
        logic [FP_W-1:0] fp;
        fp = first_page();
        if ({1'b0, region_top} < fp) return 0;
        return longint'(({1'b0, region_top} - fp) >> PAGE_SHIFT);
    endfunction

    function automatic void push_free_page(input logic [PAGE_IDX_W-1:0] page);
        page_link[page].next = head_page;
        page_link[page].last = !head_valid;
        head_page  = page;
        head_valid = 1'b1;
    endfunction

    function automatic t_rsp predict_grant(input t_req req);
        t_rsp            rsp;
        t_link           link;
        logic [FP_W-1:0] fp;
        logic [FP_W-1:0] offset;
        longint          count;
        rsp.granted_address = '0;
        rsp.status          = ST_OK;
        fp = first_page();
        case (req.kind)
            KIND_ALLOC: begin
                if (!head_valid) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.granted_address = ADDR_W'(fp + (FP_W'(head_page) << PAGE_SHIFT));
                    if (granted_pool.size() < 64) granted_pool.push_back(rsp.granted_address);
                    link       = page_link[head_page];
                    head_valid = !link.last;
                    head_page  = head_valid ? link.next : '0;
                end
            end
            KIND_FREE: begin
                if (req.page_address[PAGE_SHIFT-1:0] != '0 || req.page_address < region_base ||
                        req.page_address >= region_top || {1'b0, req.page_address} < fp) begin
                    rsp.status = ST_ERROR;
                end else begin
                    offset = ({1'b0, req.page_address} - fp) >> PAGE_SHIFT;
                    if (offset >= NUM_PAGES) rsp.status = ST_ERROR;
                    else push_free_page(offset[PAGE_IDX_W-1:0]);
                end
            end
            KIND_INIT: begin
                count = range_pages();
                if (count > NUM_PAGES) begin
                    rsp.status = ST_ERROR;
                    count = NUM_PAGES;
                end
                for (longint i = 0; i < count; i++) push_free_page(PAGE_IDX_W'(i));
            end
            default: begin
                rsp.status = ST_ERROR;
            end
        endcase
        return rsp;
    endfunction

    // start is left high after acceptance so back-to-back items keep it asserted
    task automatic send_item(input t_req req, input bit known, input t_rsp known_rsp,
                             input int idle_pct);
        t_rsp pred;
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = predict_grant(req);
        expected_rsp.push_back(known ? known_rsp : pred);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_rsp.size() != 0 || busy);
    endtask

    task automatic set_region(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] top);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_REGION_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        region_base = base;
        i_cfg_index <= REG_REGION_TOP;
        i_cfg_data  <= top;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        region_top = top;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_region(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] top);
        t_row row;
        row = '{default: '0};
        row.is_region = 1'b1;
        row.base = base;
        row.top  = top;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
        t_row row;
        row = '{default: '0};
        row.req.kind = kind;
        row.req.page_address = addr;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                                        input logic [ADDR_W-1:0] granted,
                                        input logic [1:0] status);
        t_row row;
        row = '{default: '0};
        row.req.kind = kind;
        row.req.page_address = addr;
        row.known = 1'b1;
        row.rsp.granted_address = granted;
        row.rsp.status = status;
        directed_rows.push_back(row);
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: granted %h status %0d",
                             o_rsp.granted_address, o_rsp.status);
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.granted_address !== want.granted_address ||
                        o_rsp.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: granted %h status %0d, expected granted %h status %0d",
                                 o_rsp.granted_address, o_rsp.status,
                                 want.granted_address, want.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_req              req;
        t_rsp              none;
        t_row              row;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] top;
        longint            span;
        int                idle_pct;
        int                pick;
        int                slot;

        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        none        = '0;
        region_base = '0;
        region_top  = '0;
        head_page   = '0;
        head_valid  = 1'b0;
        foreach (page_link[k]) page_link[k] = '0;

        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers: empty region
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h0, ST_EMPTY);
        add_checked(KIND_FREE,   32'h0000_0000, 32'h0, ST_ERROR);
        add_checked(KIND_UNUSED, 32'hFFFF_FFFF, 32'h0, ST_ERROR);
        add_checked(KIND_INIT,   32'h0000_0000, 32'h0, ST_OK);
        // unaligned base rounds up to 0x2000, four pages
        add_region(32'h0000_1001, 32'h0000_6000);
        add_checked(KIND_INIT,   32'h0000_0000, 32'h0, ST_OK);
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h0000_5000, ST_OK);
        add_checked(KIND_ALLOC,  32'hFFFF_FFFF, 32'h0000_4000, ST_OK);
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h0000_3000, ST_OK);
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h0000_2000, ST_OK);
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h0, ST_EMPTY);
        add_checked(KIND_FREE,   32'h0000_1000, 32'h0, ST_ERROR);
        add_checked(KIND_FREE,   32'h0000_2001, 32'h0, ST_ERROR);
        add_checked(KIND_FREE,   32'h0000_6000, 32'h0, ST_ERROR);
        add_checked(KIND_FREE,   32'h0000_5000, 32'h0, ST_OK);
        // double free links the page to itself
        add_checked(KIND_FREE,   32'h0000_5000, 32'h0, ST_OK);
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h0000_5000, ST_OK);
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h0000_5000, ST_OK);
        // whole address space: init overflows the link table
        add_region(32'h0000_0000, 32'hFFFF_FFFF);
        add_checked(KIND_INIT,   32'h0000_0000, 32'h0, ST_ERROR);
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h003F_F000, ST_OK);
        add_checked(KIND_FREE,   32'h0040_0000, 32'h0, ST_ERROR);
        add_item(KIND_FREE,      32'h003F_F000);
        add_item(KIND_FREE,      32'h0000_0000);
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h0000_0000, ST_OK);
        add_checked(KIND_ALLOC,  32'h0000_0000, 32'h003F_F000, ST_OK);
        // first page rounds up to 2^32
        add_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_checked(KIND_INIT,   32'h0000_0000, 32'h0, ST_OK);
        add_checked(KIND_FREE,   32'hFFFF_F000, 32'h0, ST_ERROR);
        add_item(KIND_ALLOC,     32'h0000_0000);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.is_region) begin
                wait_idle();
                set_region(row.base, row.top);
            end else begin
                send_item(row.req, row.known, row.rsp, 0);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    base = '0;
                    top  = '1;
                end
                1: begin
                    base = $urandom;
                    top  = base + ($urandom_range(1, 40) << PAGE_SHIFT);
                end
                2: begin
                    base = '1;
                    top  = '1;
                end
                3: begin
                    base = $urandom;
                    top  = $urandom;
                end
                4: begin
                    base = $urandom_range(0, 32'h7FFF_FFFF);
                    top  = base + (1500 << PAGE_SHIFT);
                end
                5: begin
                    base = '0;
                    top  = '0;
                end
                6: begin
                    // exactly as many pages as link slots
                    base = $urandom_range(0, 32'hBFFF_FFFF) & ~ADDR_W'(PAGE_BYTES - 1);
                    top  = base + (NUM_PAGES << PAGE_SHIFT);
                end
                default: begin
                    base = $urandom_range(0, 32'hFFFF);
                    top  = base + ($urandom_range(2, 12) << PAGE_SHIFT) +
                           $urandom_range(0, PAGE_BYTES - 1);
                end
            endcase
            case (phase % 4)
                1:       idle_pct = 53;
                3:       idle_pct = 29;
                default: idle_pct = 0;
            endcase
            wait_idle();
            set_region(base, top);
            span = range_pages();
            if (span > NUM_PAGES + 8) span = NUM_PAGES + 8;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                req.page_address = $urandom;
                pick = $urandom_range(99);
                if (pick < 42) begin
                    req.kind = KIND_ALLOC;
                end else if (pick < 84) begin
                    req.kind = KIND_FREE;
                    pick = $urandom_range(99);
                    if (pick < 45 && granted_pool.size() != 0) begin
                        slot = $urandom_range(granted_pool.size() - 1);
                        req.page_address = granted_pool[slot];
                        granted_pool.delete(slot);
                    end else if (pick < 85 && span != 0) begin
                        req.page_address = ADDR_W'(first_page() +
                            (FP_W'($urandom_range(0, int'(span - 1))) << PAGE_SHIFT));
                    end else if (pick < 92) begin
                        req.page_address = req.page_address & ~ADDR_W'(PAGE_BYTES - 1);
                    end
                end else if (pick < 96) begin
                    req.kind = KIND_INIT;
                end else begin
                    req.kind = KIND_UNUSED;
                end
                send_item(req, 1'b0, none, idle_pct);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/flpa_pkg.sv
rtl/core/flpa_ctrl.sv
rtl/core/flpa_dp.sv
rtl/core/free_list_page_allocator_core.sv
tb/free_list_page_allocator_core_test.sv
